// ===== rtl/tinl_pkg.sv =====
// Shared types and constants for the table interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tinl_pkg;

    localparam int DIST_W     = 25;
    localparam int VAL_W      = 24;
    localparam int QD_W       = 26;
    localparam int IDX_W      = 6;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int ENTRY_W    = DIST_W + VAL_W;
    localparam int PROD_W     = DIST_W + VAL_W;
    localparam int QUOT_W     = VAL_W;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [DIST_W-1:0] MAX_DISTANCE = 25'd21000000;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    localparam logic INTERP_LINEAR  = 1'b0;
    localparam logic INTERP_NEAREST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NEG   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_MID,
        ADDR_LOW,
        ADDR_HIGH
    } t_addr_sel;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ZERO,
        RES_A,
        RES_B,
        RES_RDATA,
        RES_NEAR,
        RES_SUM
    } t_res_sel;

    typedef struct packed {
        logic              take;
        t_addr_sel         addr_sel;
        logic              cap_a;
        logic              cap_b;
        logic              srch_init;
        logic              srch_step;
        logic              mul_load;
        logic              div_start;
        t_res_sel          res_sel;
        logic [STAT_W-1:0] res_stat;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic above;
        logic n_zero;
        logic n_one;
        logic nearest;
        logic x_le_a;
        logic x_ge_b;
        logic srch_done;
        logic lo_zero;
        logic lo_past;
        logic dx_bad;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/tinl_in_if.sv =====
// Input channel: valid/ready handshake with load and query fields.
`timescale 1ns / 1ps
`default_nettype none

interface tinl_in_if
    import tinl_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [IDX_W-1:0]         entry_index;
    logic [DIST_W-1:0]        breakpoint_distance;
    logic signed [VAL_W-1:0]  table_value;
    logic signed [QD_W-1:0]   query_distance;

    modport source (
        output valid, mode, entry_index, breakpoint_distance, table_value, query_distance,
        input  ready
    );

    modport sink (
        input  valid, mode, entry_index, breakpoint_distance, table_value, query_distance,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tinl_out_if.sv =====
// Output channel: valid/ready handshake with correction and status.
`timescale 1ns / 1ps
`default_nettype none

interface tinl_out_if
    import tinl_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] correction;
    logic [STAT_W-1:0]       status;

    modport source (
        output valid, correction, status,
        input  ready
    );

    modport sink (
        input  valid, correction, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/table_interpolator_nearest_linear_core.sv =====
// Top level of the breakpoint table interpolator (nearest or linear lookup).
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  i_in     | in  | valid/ready        | mode, entry_index, breakpoint_distance,
//           |     |                    | table_value, query_distance
//  o_out    | out | valid/ready        | correction, status (one per query transaction)
//  i_cfg_*  | in  | write enable only  | i_cfg_idx selects interp_mode / entry_count
//
//  A load transaction writes one table entry in the cycle it is accepted; loads go back to back.
//  The gap from one accepted query to the next is shortest on an error or an empty table;
//  otherwise the search probes set it in nearest mode, and the search probes together with
//  the 24-step divider set it in linear mode.
//  Reset is synchronous, active low; i_in.ready rises in the cycle after reset is released.
//  A finished result sits in the output register, and the next transaction is accepted while
//  it waits; a query finishing into a still-full output register holds until it drains.
`timescale 1ns / 1ps
`default_nettype none

module table_interpolator_nearest_linear_core
    import tinl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    tinl_in_if.sink                    i_in,
    tinl_out_if.source                 o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // sequencing: checks, search probes, pair reads, multiply, divide
    tinl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // table memory, bounds, arithmetic and the output register
    tinl_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_mode             (i_in.mode),
        .i_entry_index         (i_in.entry_index),
        .i_breakpoint_distance (i_in.breakpoint_distance),
        .i_table_value         (i_in.table_value),
        .i_query_distance      (i_in.query_distance),
        .i_out_ready           (o_out.ready),
        .i_cmd                 (w_cmd),
        .o_sts                 (w_sts),
        .o_out_valid           (o_out.valid),
        .o_correction          (o_out.correction),
        .o_status              (o_out.status)
    );

    assign i_in.ready = w_in_ready;

endmodule

`default_nettype wire

// ===== rtl/tinl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tinl_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tinl_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tinl_div
    import tinl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_dividend,
    input  wire logic [DIST_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic [QUOT_W-1:0]      o_quot
);

    // dividend < divisor * 2^QUOT_W, so the high part starts below the divisor
    logic [DIST_W-1:0]    r_rem;
    logic [QUOT_W-1:0]    r_low;
    logic [DIST_W-1:0]    r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [DIST_W:0]      w_trial;
    logic [DIST_W:0]      w_diff;
    logic                 w_fit;

    assign w_trial = {r_rem, r_low[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:QUOT_W];
            r_low <= i_dividend[QUOT_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? w_diff[DIST_W-1:0] : w_trial[DIST_W-1:0];
            r_low <= {r_low[QUOT_W-2:0], w_fit};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_low;

endmodule

`default_nettype wire

// ===== rtl/tinl_dpath.sv =====
// Datapath: table memory, search bounds, multiplier, divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module tinl_dpath
    import tinl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_mode,
    input  wire logic [IDX_W-1:0]        i_entry_index,
    input  wire logic [DIST_W-1:0]       i_breakpoint_distance,
    input  wire logic signed [VAL_W-1:0] i_table_value,
    input  wire logic signed [QD_W-1:0]  i_query_distance,
    input  wire logic                    i_out_ready,
    input  wire t_cmd                    i_cmd,
    output t_sts                         o_sts,
    output logic                         o_out_valid,
    output logic signed [VAL_W-1:0]      o_correction,
    output logic [STAT_W-1:0]            o_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic                  r_interp_mode;
    logic [CFG_DATA_W-1:0] r_entry_count;

    // query and working registers
    logic [QD_W-1:0]         r_qd;
    logic [DIST_W-1:0]       r_a_d;
    logic signed [VAL_W-1:0] r_a_v;
    logic [DIST_W-1:0]       r_b_d;
    logic signed [VAL_W-1:0] r_b_v;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_prod_neg;
    logic signed [VAL_W-1:0] r_res;
    logic [STAT_W-1:0]       r_stat;

    // output register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_corr;
    logic [STAT_W-1:0]       r_out_status;

    logic [CW-1:0]           w_n;
    logic [CW-1:0]           w_last;
    logic [CW-1:0]           w_mid;
    logic [CW-1:0]           w_lo_m1;
    logic [DIST_W-1:0]       w_x;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [AW-1:0]           w_raddr;
    logic [ENTRY_W-1:0]      w_rdata;
    logic [DIST_W-1:0]       w_rd_d;
    logic signed [VAL_W-1:0] w_rd_v;
    logic                    w_go_right;
    logic signed [DIST_W:0]  w_below;
    logic signed [DIST_W:0]  w_above;
    logic signed [DIST_W:0]  w_dx;
    logic [DIST_W-1:0]       w_dxx;
    logic signed [VAL_W:0]   w_dy;
    logic [VAL_W:0]          w_dy_mag;
    logic [PROD_W-1:0]       w_prod;
    logic                    w_div_busy;
    logic [QUOT_W-1:0]       w_quot;
    logic signed [VAL_W:0]   w_q_s;
    logic signed [VAL_W+1:0] w_sum;
    logic signed [VAL_W-1:0] w_sum_sat;
    logic signed [VAL_W-1:0] n_res;

    // entries in use, capped at the table depth
    assign w_n = (int'(r_entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                     : CW'(r_entry_count);
    assign w_last  = w_n - 1'b1;
    assign w_mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign w_lo_m1 = r_lo - 1'b1;
    assign w_x     = r_qd[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp_mode <= INTERP_LINEAR;
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INTERP_MODE: r_interp_mode <= i_cfg_data[0];
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table memory: {distance, value}
    assign w_we    = i_cmd.take && (i_in_mode == MODE_LOAD) &&
                     (int'(i_entry_index) < TABLE_DEPTH);
    assign w_waddr = AW'(i_entry_index);

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_ZERO: w_raddr = '0;
            ADDR_LAST: w_raddr = w_last[AW-1:0];
            ADDR_MID:  w_raddr = w_mid[AW-1:0];
            ADDR_LOW:  w_raddr = w_lo_m1[AW-1:0];
            ADDR_HIGH: w_raddr = r_lo[AW-1:0];
            default:   w_raddr = '0;
        endcase
    end

    tinl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_breakpoint_distance, i_table_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_d = w_rdata[ENTRY_W-1:VAL_W];
    assign w_rd_v = w_rdata[VAL_W-1:0];

    // linear mode searches for the first entry above x, nearest for the first at or above
    assign w_go_right = (r_interp_mode == INTERP_NEAREST) ? (w_rd_d < w_x) : (w_rd_d <= w_x);

    assign w_below = $signed({1'b0, w_x}) - $signed({1'b0, r_a_d});
    assign w_above = $signed({1'b0, r_b_d}) - $signed({1'b0, w_x});
    assign w_dx    = $signed({1'b0, r_b_d}) - $signed({1'b0, r_a_d});

    // x lies in [x0, x1) here, so the offset is non-negative
    assign w_dxx    = w_x - r_a_d;
    assign w_dy     = $signed({r_b_v[VAL_W-1], r_b_v}) - $signed({r_a_v[VAL_W-1], r_a_v});
    assign w_dy_mag = w_dy[VAL_W] ? VAL_W'(0) - w_dy : w_dy;
    assign w_prod   = PROD_W'(w_dxx) * PROD_W'(w_dy_mag[VAL_W-1:0]);

    tinl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_dx[DIST_W-1:0]),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign w_q_s = r_prod_neg ? $signed(-{1'b0, w_quot}) : $signed({1'b0, w_quot});
    assign w_sum = $signed({{2{r_a_v[VAL_W-1]}}, r_a_v}) + $signed({w_q_s[VAL_W], w_q_s});

    always_comb begin
        if (w_sum[VAL_W+1:VAL_W-1] == 3'b000 || w_sum[VAL_W+1:VAL_W-1] == 3'b111) begin
            w_sum_sat = w_sum[VAL_W-1:0];
        end else if (w_sum[VAL_W+1]) begin
            w_sum_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            w_sum_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_comb begin
        case (i_cmd.res_sel)
            RES_ZERO:  n_res = '0;
            RES_A:     n_res = r_a_v;
            RES_B:     n_res = r_b_v;
            RES_RDATA: n_res = w_rd_v;
            RES_NEAR:  n_res = (w_below <= w_above) ? r_a_v : r_b_v;
            RES_SUM:   n_res = w_sum_sat;
            default:   n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in_mode == MODE_QUERY)) begin
            r_qd <= i_query_distance;
        end
        if (i_cmd.cap_a) begin
            r_a_d <= w_rd_d;
            r_a_v <= w_rd_v;
        end
        if (i_cmd.cap_b) begin
            r_b_d <= w_rd_d;
            r_b_v <= w_rd_v;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= w_n;
        end else if (i_cmd.srch_step) begin
            if (w_go_right) begin
                r_lo <= w_mid + 1'b1;
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.mul_load) begin
            r_prod     <= w_prod;
            r_prod_neg <= w_dy[VAL_W];
        end
        if (i_cmd.res_sel != RES_NONE) begin
            r_res  <= n_res;
            r_stat <= i_cmd.res_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_corr   <= r_res;
            r_out_status <= r_stat;
        end
    end

    assign o_sts.neg       = r_qd[QD_W-1];
    assign o_sts.above     = (w_x > MAX_DISTANCE);
    assign o_sts.n_zero    = (w_n == '0);
    assign o_sts.n_one     = (w_n == CW'(1));
    assign o_sts.nearest   = (r_interp_mode == INTERP_NEAREST);
    assign o_sts.x_le_a    = (w_x <= r_a_d);
    assign o_sts.x_ge_b    = (w_x >= r_b_d);
    assign o_sts.srch_done = (r_lo >= r_hi);
    assign o_sts.lo_zero   = (r_lo == '0);
    assign o_sts.lo_past   = (r_lo >= w_n);
    assign o_sts.dx_bad    = w_dx[DIST_W] || (w_dx == '0);
    assign o_sts.div_done  = !w_div_busy;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_correction = r_out_corr;
    assign o_status     = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/tinl_ctrl.sv =====
// Controller: sequences the checks, table search, interpolation and output.
`timescale 1ns / 1ps
`default_nettype none

module tinl_ctrl
    import tinl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_mode,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_FIRST_CAP,
        S_FIRST_CHK,
        S_LAST_CAP,
        S_LAST_CHK,
        S_SRCH_ADDR,
        S_SRCH_CMP,
        S_SRCH_END,
        S_END_CAP,
        S_PAIR_HIGH,
        S_PAIR_CAP,
        S_PAIR_CHK,
        S_DIV_START,
        S_DIV_RUN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_ZERO;
        o_cmd.res_sel  = RES_NONE;
        o_cmd.res_stat = STAT_OK;

        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid && r_in_ready;
                if (o_cmd.take && (i_in_mode == MODE_QUERY)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.neg) begin
                    o_cmd.res_sel  = RES_ZERO;
                    o_cmd.res_stat = STAT_NEG;
                    n_state        = S_DONE;
                end else if (i_sts.above) begin
                    o_cmd.res_sel  = RES_ZERO;
                    o_cmd.res_stat = STAT_RANGE;
                    n_state        = S_DONE;
                end else if (i_sts.n_zero) begin
                    o_cmd.res_sel = RES_ZERO;
                    n_state       = S_DONE;
                end else if (i_sts.n_one || !i_sts.nearest) begin
                    o_cmd.addr_sel = ADDR_ZERO;
                    n_state        = S_FIRST_CAP;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SRCH_ADDR;
                end
            end
            S_FIRST_CAP: begin
                o_cmd.cap_a = 1'b1;
                n_state     = S_FIRST_CHK;
            end
            S_FIRST_CHK: begin
                if (i_sts.n_one || i_sts.x_le_a) begin
                    o_cmd.res_sel = RES_A;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.addr_sel = ADDR_LAST;
                    n_state        = S_LAST_CAP;
                end
            end
            S_LAST_CAP: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_LAST_CHK;
            end
            S_LAST_CHK: begin
                if (i_sts.x_ge_b) begin
                    o_cmd.res_sel = RES_B;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SRCH_ADDR;
                end
            end
            S_SRCH_ADDR: begin
                if (i_sts.srch_done) begin
                    n_state = S_SRCH_END;
                end else begin
                    o_cmd.addr_sel = ADDR_MID;
                    n_state        = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.srch_step = 1'b1;
                n_state         = S_SRCH_ADDR;
            end
            S_SRCH_END: begin
                if (!i_sts.nearest && (i_sts.lo_zero || i_sts.lo_past)) begin
                    // only reachable with an unsorted table; entry 0 is in A
                    o_cmd.res_sel = RES_A;
                    n_state       = S_DONE;
                end else if (i_sts.lo_zero) begin
                    o_cmd.addr_sel = ADDR_ZERO;
                    n_state        = S_END_CAP;
                end else if (i_sts.lo_past) begin
                    o_cmd.addr_sel = ADDR_LAST;
                    n_state        = S_END_CAP;
                end else begin
                    o_cmd.addr_sel = ADDR_LOW;
                    n_state        = S_PAIR_HIGH;
                end
            end
            S_END_CAP: begin
                o_cmd.res_sel = RES_RDATA;
                n_state       = S_DONE;
            end
            S_PAIR_HIGH: begin
                o_cmd.cap_a    = 1'b1;
                o_cmd.addr_sel = ADDR_HIGH;
                n_state        = S_PAIR_CAP;
            end
            S_PAIR_CAP: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_PAIR_CHK;
            end
            S_PAIR_CHK: begin
                if (i_sts.nearest) begin
                    o_cmd.res_sel = RES_NEAR;
                    n_state       = S_DONE;
                end else if (i_sts.dx_bad) begin
                    o_cmd.res_sel = RES_A;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.mul_load = 1'b1;
                    n_state        = S_DIV_START;
                end
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (i_sts.div_done) begin
                    o_cmd.res_sel = RES_SUM;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

`default_nettype wire

// ===== rtl/tinl_checker.sv =====
// Port-level checks for the interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tinl_checker
    import tinl_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire logic                    i_in_mode,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [VAL_W-1:0] i_correction,
    input wire logic [STAT_W-1:0]       i_status
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_correction) && $stable(i_status))
        else $error("result changed while stalled");

    // a query occupies the block: no new transaction the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_mode == MODE_QUERY) |=> !i_in_ready)
        else $error("input ready right after a query");

    // a load finishes in its own cycle
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_mode == MODE_LOAD) |=> i_in_ready)
        else $error("input not ready after a load");

    // errors carry a zero correction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != STAT_OK) |-> (i_correction == '0))
        else $error("nonzero correction on error status");

    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == STAT_OK || i_status == STAT_NEG ||
                         i_status == STAT_RANGE))
        else $error("unknown status code");

endmodule

bind table_interpolator_nearest_linear_core tinl_checker u_tinl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_mode    (i_in.mode),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_correction (o_out.correction),
    .i_status     (o_out.status)
);

`default_nettype wire

// ===== test/tinl_checker.sv =====
// Checker for the table interpolator: tracks the table and registers, predicts each query.
`timescale 1ns / 1ps

module tinl_tb_checker
    import tinl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tinl_in_if                    i_in_ch,
    tinl_out_if                   i_out_ch,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam longint VAL_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
    localparam longint VAL_MIN = -(longint'(1) <<< (VAL_W - 1));

    typedef struct packed {
        logic [VAL_W-1:0]  correction;
        logic [STAT_W-1:0] status;
    } t_corr_result;

    // Shadow of the breakpoint table and the two registers
    logic [DIST_W-1:0]       bp_mem  [TABLE_DEPTH];
    logic signed [VAL_W-1:0] val_mem [TABLE_DEPTH];
    logic                    cur_interp;
    logic [CFG_DATA_W-1:0]   cur_count;

    t_corr_result pending_corrections[$];
    t_corr_result want;
    int           mismatches;
    int           queries_seen;
    int           results_seen;

    assign o_mismatches = mismatches;
    assign o_pending    = queries_seen - results_seen;

    initial begin
        mismatches   = 0;
        queries_seen = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    // First index in [0,n) whose distance is >= x, or > x when past_equal is set; n if none
    function automatic int unsigned first_index_from(input int unsigned n, input longint x,
                                                     input bit past_equal);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        longint      d;
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            d   = longint'(bp_mem[mid]);
            if (past_equal ? (d <= x) : (d < x)) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic longint nearest_value(input int unsigned n, input longint x);
        int unsigned i;
        i = first_index_from(n, x, 1'b0);
        if (i == 0) return longint'(val_mem[0]);
        if (i >= n) return longint'(val_mem[n-1]);
        // tie goes to the lower breakpoint
        if (x - longint'(bp_mem[i-1]) <= longint'(bp_mem[i]) - x) return longint'(val_mem[i-1]);
        return longint'(val_mem[i]);
    endfunction

    function automatic longint linear_value(input int unsigned n, input longint x);
        int unsigned i;
        longint      x0;
        longint      dx;
        longint      y0;
        longint      r;
        if (x <= longint'(bp_mem[0])) return longint'(val_mem[0]);
        if (x >= longint'(bp_mem[n-1])) return longint'(val_mem[n-1]);
        i = first_index_from(n, x, 1'b1);
        if (i == 0 || i >= n) return longint'(val_mem[0]);
        i  = i - 1;
        x0 = longint'(bp_mem[i]);
        dx = longint'(bp_mem[i+1]) - x0;
        y0 = longint'(val_mem[i]);
        if (dx <= 0) return y0;
        // SV division on longint truncates toward zero
        r = y0 + ((x - x0) * (longint'(val_mem[i+1]) - y0)) / dx;
        if (r > VAL_MAX) r = VAL_MAX;
        if (r < VAL_MIN) r = VAL_MIN;
        return r;
    endfunction

    function automatic t_corr_result predict_correction(input logic signed [QD_W-1:0] qd);
        t_corr_result r;
        int unsigned  n;
        longint       x;
        r.correction = '0;
        r.status     = STAT_OK;
        n = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
        x = longint'(qd);
        if (x < 0) begin
            r.status = STAT_NEG;
        end else if (x > longint'(MAX_DISTANCE)) begin
            r.status = STAT_RANGE;
        end else if (n == 1) begin
            r.correction = val_mem[0];
        end else if (n > 1) begin
            if (cur_interp == INTERP_NEAREST) begin
                r.correction = VAL_W'(nearest_value(n, x));
            end else begin
                r.correction = VAL_W'(linear_value(n, x));
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_interp   = INTERP_LINEAR;
            cur_count    = '0;
            pending_corrections.delete();
            queries_seen <= 0;
            results_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INTERP_MODE: cur_interp = i_cfg_data[0];
                    CFG_ENTRY_COUNT: cur_count  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (i_in_ch.mode == MODE_LOAD) begin
                    bp_mem[i_in_ch.entry_index]  = i_in_ch.breakpoint_distance;
                    val_mem[i_in_ch.entry_index] = i_in_ch.table_value;
                end else begin
                    pending_corrections = {pending_corrections,
                                           predict_correction(i_in_ch.query_distance)};
                    queries_seen <= queries_seen + 1;
                end
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                results_seen <= results_seen + 1;
                if (pending_corrections.size() == 0) begin
                    report_mismatch($sformatf("result (correction %0d, status %0d) with no query",
                                              i_out_ch.correction, i_out_ch.status));
                end else begin
                    want = pending_corrections.pop_front();
                    if (i_out_ch.correction !== want.correction) begin
                        report_mismatch($sformatf("correction %0d, predicted %0d",
                                                  i_out_ch.correction,
                                                  $signed(want.correction)));
                    end
                    if (i_out_ch.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  i_out_ch.status, want.status));
                    end
                end
            end
        end
    end

endmodule

// ===== test/table_interpolator_nearest_linear_core_tb.sv =====
// Testbench top for the table interpolator: stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module table_interpolator_nearest_linear_core_tb;
    import tinl_pkg::*;

    localparam int     TABLE_SLOTS    = 64;
    localparam int     RANDOM_ITEMS   = 1300;   // random transactions before wrap-up
    localparam int     SETTLE_CYCLES  = 64;     // covers the longest query in linear mode
    localparam int     RX_HOLD_CYCLES = 400;    // long output back-pressure stretch
    localparam int     CYCLE_LIMIT    = 600000; // watchdog, several times the slowest run
    localparam longint DIST_LIMIT     = longint'(MAX_DISTANCE);

    // How breakpoints are spaced when a phase rebuilds the table
    typedef enum logic [1:0] {
        SPREAD_DENSE,     // steps of 0..3 m, duplicates included
        SPREAD_MEDIUM,
        SPREAD_WIDE,      // spans up to the distance limit
        SPREAD_SCRAMBLED  // unsorted, any 25-bit distance
    } t_spread;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tinl_in_if  in_ch ();
    tinl_out_if out_ch ();

    int checker_mismatches;
    int checker_pending;
    int cycle_count = 0;
    int hold_requests = 0;   // bumped by stimulus, served by the output-side process
    bit tx_quiet = 1'b0;     // sender offers back to back when set

    // Distances last loaded per slot, only used to aim queries
    logic [DIST_W-1:0] table_dist [TABLE_SLOTS];

    table_interpolator_nearest_linear_core #(
        .TABLE_DEPTH (TABLE_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    tinl_tb_checker #(
        .TABLE_DEPTH (TABLE_SLOTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_mismatches (checker_mismatches),
        .o_pending    (checker_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles", CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // One input transaction. Random gap in front unless the phase runs quiet; returns at
    // the edge where the transaction is accepted, leaving valid high for the caller.
    task automatic offer(input logic mode, input logic [IDX_W-1:0] slot,
                         input logic [DIST_W-1:0] bp_dist, input logic [VAL_W-1:0] value,
                         input logic [QD_W-1:0] qd);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid               <= 1'b1;
        in_ch.mode                <= mode;
        in_ch.entry_index         <= slot;
        in_ch.breakpoint_distance <= bp_dist;
        in_ch.table_value         <= value;
        in_ch.query_distance      <= qd;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Query: the load fields carry junk, the block must ignore them
    task automatic send_query(input longint qd);
        offer(MODE_QUERY, IDX_W'($urandom), DIST_W'($urandom), VAL_W'($urandom), qd[QD_W-1:0]);
    endtask

    // Load: query_distance carries junk
    task automatic send_load(input logic [IDX_W-1:0] slot, input logic [DIST_W-1:0] bp_dist,
                             input logic [VAL_W-1:0] value);
        table_dist[slot] = bp_dist;
        offer(MODE_LOAD, slot, bp_dist, value, QD_W'($urandom));
    endtask

    // Drop valid, wait for every predicted result, then let any load or late query finish.
    // The first edge lets the checker count a query accepted at the current edge.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (checker_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both registers are written back to back, only while the block is idle
    task automatic set_config(input logic interp, input logic [CFG_DATA_W-1:0] count);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INTERP_MODE;
        i_cfg_data <= CFG_DATA_W'(interp);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ENTRY_COUNT;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Output side: random stall per result, quiet stretches, and a long hold on request
    // so that the result register fills and the block stalls its input.
    initial begin
        int stall;
        int holds_done;
        bit rx_quiet;
        holds_done = 0;
        rx_quiet   = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_requests > holds_done) begin
                holds_done++;
                out_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        longint      plan_dist [TABLE_SLOTS];
        longint      d;
        longint      span;
        longint      base;
        longint      qd;
        longint      span_hi;
        int          items_sent;
        int          phase;
        int          n;
        int          k;
        int          rot;
        int          sel;
        int          nq;
        logic        interp;
        logic [CFG_DATA_W-1:0] count;
        t_spread     spread;

        in_ch.valid               <= 1'b0;
        in_ch.mode                <= MODE_QUERY;
        in_ch.entry_index         <= '0;
        in_ch.breakpoint_distance <= '0;
        in_ch.table_value         <= '0;
        in_ch.query_distance      <= '0;
        i_cfg_we                  <= 1'b0;
        i_cfg_idx                 <= CFG_INTERP_MODE;
        i_cfg_data                <= '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // ---------------- directed part ----------------
        // Empty table: ok status with zero, plus both error statuses at their edges
        set_config(INTERP_LINEAR, 7'd0);
        send_query(0);
        send_query(-1);
        send_query(-33554432);
        send_query(DIST_LIMIT);
        send_query(DIST_LIMIT + 1);
        send_query(33554431);

        // Three breakpoints with the extreme values
        send_load(6'd0, 25'd100, 24'h800000);
        send_load(6'd1, 25'd200, 24'h7FFFFF);
        send_load(6'd2, 25'd300, 24'h000000);

        // Single entry answers with its own value wherever the query lands
        wait_idle();
        set_config(INTERP_LINEAR, 7'd1);
        send_query(5000000);

        // Linear: on a breakpoint, between, below the first and above the last
        wait_idle();
        set_config(INTERP_LINEAR, 7'd3);
        send_query(100);
        send_query(150);
        send_query(250);
        send_query(0);
        send_query(301);
        send_query(DIST_LIMIT);

        // Nearest: exact midpoints go to the lower entry
        wait_idle();
        set_config(INTERP_NEAREST, 7'd3);
        send_query(150);
        send_query(151);
        send_query(249);
        send_query(250);
        send_query(0);
        send_query(DIST_LIMIT);

        // Break the ordering: the search still runs as specified
        send_load(6'd1, 25'd400, 24'd12345);
        send_query(350);
        send_query(250);

        // ---------------- random phases ----------------
        // Each phase: idle, new registers, rebuild the first n slots, then a query stream
        // with a few stray loads. Phase 0 fills all 64 slots so later phases never read an
        // unwritten entry, and uses a count beyond the table size.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();

            sel = $urandom_range(0, 15);
            if (phase < 2 || sel == 2) begin
                n = TABLE_SLOTS;
            end else if (sel == 0) begin
                n = 0;
            end else if (sel == 1) begin
                n = 1;
            end else begin
                n = $urandom_range(2, 12);
            end

            if (phase == 0) begin
                interp = INTERP_LINEAR;
            end else if (phase == 1) begin
                interp = INTERP_NEAREST;
            end else begin
                interp = 1'($urandom_range(0, 1));
            end

            count = CFG_DATA_W'(n);
            if (phase == 0) begin
                count = 7'd127;
            end else if (n == TABLE_SLOTS && $urandom_range(0, 1) == 1) begin
                count = CFG_DATA_W'($urandom_range(TABLE_SLOTS, 127));
            end
            set_config(interp, count);

            if (phase == 0) begin
                spread = SPREAD_WIDE;
            end else if (phase == 1) begin
                spread = SPREAD_DENSE;
            end else begin
                case ($urandom_range(0, 5))
                    0:       spread = SPREAD_DENSE;
                    1:       spread = SPREAD_WIDE;
                    2:       spread = SPREAD_SCRAMBLED;
                    default: spread = SPREAD_MEDIUM;
                endcase
            end

            // Plan the breakpoints, then load them starting from a random slot
            d    = longint'($urandom_range(0, 1000));
            span = 0;
            for (k = 0; k < n; k++) begin
                case (spread)
                    SPREAD_DENSE:  d = d + longint'($urandom_range(0, 3));
                    SPREAD_MEDIUM: d = d + longint'($urandom_range(1, 2000));
                    SPREAD_WIDE:   d = d + longint'($urandom_range(1, 2 * (21000000 / n)));
                    default:       d = longint'($urandom_range(0, 33554431));
                endcase
                if (spread != SPREAD_SCRAMBLED && d > DIST_LIMIT) d = DIST_LIMIT;
                plan_dist[k] = d;
                if (d > span) span = d;
            end
            rot = (n > 0) ? $urandom_range(0, n - 1) : 0;
            tx_quiet = 1'b0;
            for (k = 0; k < n; k++) begin
                send_load(IDX_W'((k + rot) % n), DIST_W'(plan_dist[(k + rot) % n]),
                          VAL_W'($urandom));
            end
            items_sent += n;

            // Phase 2 floods the input while the output side holds off
            tx_quiet = (phase == 2) || ($urandom_range(0, 3) == 0);
            if (phase == 2) hold_requests++;

            span_hi = (span + 1000 > DIST_LIMIT) ? DIST_LIMIT : span + 1000;
            nq = $urandom_range(40, 80);
            for (int j = 0; j < nq; j++) begin
                if ($urandom_range(0, 24) == 0) begin
                    // stray load, may well unsort the table
                    send_load(IDX_W'($urandom_range(0, TABLE_SLOTS - 1)), DIST_W'($urandom),
                              VAL_W'($urandom));
                end else begin
                    sel  = $urandom_range(0, 9);
                    k    = (n > 0) ? $urandom_range(0, n - 1) : 0;
                    base = longint'(table_dist[k]);
                    case (sel)
                        0, 1, 2: qd = base;
                        3:       qd = base + longint'($urandom_range(0, 2)) - 1;
                        4:       qd = (k + 1 < n)
                                      ? (base + longint'(table_dist[k + 1])) / 2
                                        + longint'($urandom_range(0, 1))
                                      : base;
                        5, 6:    qd = longint'($urandom_range(0, int'(span_hi)));
                        7:       qd = DIST_LIMIT - 2 + longint'($urandom_range(0, 4));
                        8:       qd = -longint'($urandom_range(1, 33554432));
                        default: qd = longint'($urandom);
                    endcase
                    send_query(qd);
                end
            end
            items_sent += nq;
            phase++;
        end

        wait_idle();
        if (checker_mismatches == 0 && checker_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
